// File: rtl/apath_pkg.sv
// Shared constants and types for the path hash block.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package apath_pkg;

  localparam int MAX_PATH_BYTES = 256;
  // Byte counter holds 0 .. MAX_PATH_BYTES + 1 (saturated).
  localparam int CNT_W = $clog2(MAX_PATH_BYTES + 2);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [31:0] SUFFIX_A   = 32'h9BE74448;
  localparam logic [31:0] SUFFIX_B   = 32'h66F42C48;
  localparam logic [31:0] INIT_ROT   = 32'hF4FA8928;
  localparam logic [31:0] INIT_LEFT  = 32'h7758B42B;
  localparam logic [31:0] INIT_RIGHT = 32'h37A8470E;
  localparam logic [31:0] MIX_KEY    = 32'h267B0B11;
  localparam logic [31:0] F1_SET     = 32'h02040801;
  localparam logic [31:0] F1_KEEP    = 32'hBFEF7FDF;
  localparam logic [31:0] F2_SET     = 32'h00804021;
  localparam logic [31:0] F2_KEEP    = 32'h7DFEFBFF;

  // Command from front to back: an optional word round, optionally the
  // end of the path (suffix rounds and result).
  typedef struct packed {
    logic        has_word;
    logic        finish;
    logic        err;
    logic [31:0] word;
  } apath_cmd_t;

endpackage

`default_nettype wire

// File: rtl/apath_queue.sv
// Small command queue between front and back of the path hash.
// Depends on apath_pkg.
`default_nettype none

module apath_queue (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  apath_pkg::apath_cmd_t       push_data,
  output logic                        full,
  input  wire                         pop,
  output logic                        empty,
  output apath_pkg::apath_cmd_t       pop_data
);
  import apath_pkg::*;

  apath_cmd_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/apath_front.sv
// Front end: takes path bytes, packs words, tracks count and errors.
// Depends on apath_pkg; feeds apath_queue.
`default_nettype none

module apath_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_path_byte,
  input  wire                   in_byte_present,
  input  wire                   in_last_byte,
  output logic                  push,
  output apath_pkg::apath_cmd_t push_data,
  input  wire                   q_full
);
  import apath_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATH_BYTES);
  localparam logic [CNT_W-1:0] SAT_CNT = CNT_W'(MAX_PATH_BYTES + 1);

  logic [31:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bad_r, bad_nxt;
  logic             accept, word_full, err;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    bad_nxt   = bad_r | (in_byte_present & in_path_byte[7]);
    word_full = 1'b0;
    if (in_byte_present) begin
      if (cnt_r < MAX_CNT) begin
        acc_nxt   = acc_r | ({24'b0, in_path_byte} << {cnt_r[1:0], 3'b000});
        cnt_nxt   = cnt_r + 1'b1;
        word_full = (cnt_nxt[1:0] == 2'b00);
      end else begin
        cnt_nxt = SAT_CNT;
      end
    end
    err = bad_nxt | (cnt_nxt > MAX_CNT);

    push_data.word     = acc_nxt;
    push_data.finish   = in_last_byte;
    push_data.err      = in_last_byte & err;
    // A partial word only runs when the path is clean; an error zeroes it all.
    push_data.has_word = word_full |
                         (in_last_byte & !err & (cnt_nxt[1:0] != 2'b00));
    push = accept & (word_full | in_last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else if (accept) begin
      if (in_last_byte) begin
        acc_r <= '0;
        cnt_r <= '0;
        bad_r <= 1'b0;
      end else begin
        acc_r <= word_full ? 32'b0 : acc_nxt;
        cnt_r <= cnt_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/apath_back.sv
// Back end: runs mixing rounds on a shared 32x32 multiplier, emits results.
// Depends on apath_pkg; drains apath_queue.
`default_nettype none

module apath_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  apath_pkg::apath_cmd_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           out_hash_value,
  output logic                  out_path_error
);
  import apath_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FOLD = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] SFX_WORD = 2'd0;
  localparam logic [1:0] SFX_A    = 2'd1;
  localparam logic [1:0] SFX_B    = 2'd2;

  logic [2:0]  state_r;
  logic [31:0] rot_r, left_r, right_r, f1_r, f2_r, word_r;
  logic [63:0] prod_r;
  logic [1:0]  sfx_r;
  logic        fin_r, err_r;
  logic        out_valid_r, out_err_r;
  logic [31:0] out_hash_r;

  logic [31:0] rot_nxt, mix, w, rl, ll, mul_a, mul_b;
  logic [31:0] fold_r, fold_l, lo1_r, lo1_l, dh;
  logic [32:0] s_r, s_l;
  logic        out_free;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_path_error = out_err_r;
  assign out_free       = !out_valid_r || out_ready;
  assign pop            = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    rot_nxt = {rot_r[30:0], rot_r[31]};
    mix     = MIX_KEY ^ rot_nxt;
    case (sfx_r)
      SFX_WORD: w = word_r;
      SFX_A:    w = SUFFIX_A;
      default:  w = SUFFIX_B;
    endcase
    rl = right_r ^ w;
    ll = left_r ^ w;

    // One multiplier, operands picked by the step.
    mul_a = (state_r == ST_MUL1) ? f1_r : left_r;
    mul_b = (state_r == ST_MUL1) ? right_r : f2_r;

    // Right lane: end-around fold of the high half.
    lo1_r  = prod_r[31:0] + {31'b0, |prod_r[63:32]};
    s_r    = {1'b0, lo1_r} + {1'b0, prod_r[63:32]};
    fold_r = s_r[31:0] + {31'b0, s_r[32]};

    // Left lane: doubled high half folded back, carries worth two.
    dh     = {prod_r[62:32], 1'b0};
    lo1_l  = prod_r[31:0] + {31'b0, prod_r[63]};
    s_l    = {1'b0, lo1_l} + {1'b0, dh};
    fold_l = s_l[31:0] + (s_l[32] ? 32'd2 : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL1 || state_r == ST_MUL2) begin
      prod_r <= {32'b0, mul_a} * {32'b0, mul_b};
    end
    if (state_r == ST_MIX) begin
      f1_r <= ((mix + ll) | F1_SET) & F1_KEEP;
      f2_r <= ((mix + rl) | F2_SET) & F2_KEEP;
    end
    if (pop) begin
      word_r <= q_data.word;
    end
    if (state_r == ST_DONE && out_free) begin
      out_hash_r <= err_r ? 32'b0 : (right_r ^ left_r);
      out_err_r  <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= INIT_ROT;
      left_r      <= INIT_LEFT;
      right_r     <= INIT_RIGHT;
      sfx_r       <= SFX_WORD;
      fin_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || (state_r == ST_DONE && out_free);
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            fin_r <= q_data.finish;
            err_r <= q_data.err;
            sfx_r <= q_data.has_word ? SFX_WORD : SFX_A;
            state_r <= (q_data.finish && q_data.err) ? ST_DONE : ST_MIX;
          end
        end
        ST_MIX: begin
          rot_r   <= rot_nxt;
          right_r <= rl;
          left_r  <= ll;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          right_r <= fold_r;
          state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          left_r <= fold_l;
          if (!fin_r) begin
            state_r <= ST_IDLE;
          end else if (sfx_r == SFX_B) begin
            state_r <= ST_DONE;
          end else begin
            sfx_r   <= sfx_r + 1'b1;
            state_r <= ST_MIX;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rot_r   <= INIT_ROT;
            left_r  <= INIT_LEFT;
            right_r <= INIT_RIGHT;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/archive_path_hash.sv
// Path hash top level: front end, command queue and round engine.
// Depends on apath_pkg, apath_front, apath_queue and apath_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one request per path byte, with
//    in_byte_present set; in_last_byte marks the end of the path. A request
//    with in_byte_present low and in_last_byte high ends an empty path; one
//    with both low is ignored.
//  - Output channel (out_valid/out_ready): one request per path, carrying
//    out_hash_value and out_path_error (hash zero when the error is set:
//    a byte >= 0x80 or more than MAX_PATH_BYTES bytes).
//  - Throughput: the front takes a byte each cycle while the queue has
//    room. Every fourth byte makes a word round, which the back end runs
//    as queue pop, mix, two passes of the shared 32x32 multiplier and
//    fold, so long paths are paced by the back end's word rounds.
//  - After the last request reaches the back end, up to three rounds
//    (last partial word plus two suffix words) run before the result; an
//    error path skips the rounds and goes straight to the result.
//  - Reset (rst_n low, synchronous) empties the queue and restores the
//    lane seeds; the block takes bytes in the next cycle.
//  - A stalled receiver holds the result in the output register; word
//    rounds of the next path go on, and the next result waits for it.
`default_nettype none

module archive_path_hash (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_path_byte,
  input  wire         in_byte_present,
  input  wire         in_last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_hash_value,
  output logic        out_path_error
);
  import apath_pkg::*;

  apath_cmd_t push_data, pop_data;
  logic       push, pop, q_full, q_empty;

  // Byte packing, counting and error tracking.
  apath_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_path_byte    (in_path_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  // Decouples byte intake from the multi-cycle rounds.
  apath_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  // Round engine and result register.
  apath_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .out_path_error (out_path_error)
  );

endmodule

`default_nettype wire

// File: rtl/apath_checker.sv
// Port-level checks for the path hash top level, bound to it below.
// Depends only on the top level's ports.
`default_nettype none

module apath_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire [7:0]  in_path_byte,
  input wire        in_byte_present,
  input wire        in_last_byte,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_hash_value,
  input wire        out_path_error
);

  // Reset leaves no result pending and the input open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result pending or input blocked after reset");

  // An error result never carries a hash.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_path_error) |-> (out_hash_value == 32'b0))
    else $error("error result with nonzero hash");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_hash_value) && $stable(out_path_error)))
    else $error("result changed while stalled");

  // A waiting byte request stays put until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable({in_path_byte, in_byte_present, in_last_byte})))
    else $error("byte request changed while waiting");

endmodule

bind archive_path_hash apath_checker u_apath_checker (.*);

`default_nettype wire

// File: verif/path_hash_checker.sv
// Checker for the path hash block: tracks byte requests, predicts each hash.
// Compares every result request against the prediction; needs apath_pkg only.
`timescale 1ns / 100ps

module path_hash_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [7:0]  in_path_byte,
  input  wire        in_byte_present,
  input  wire        in_last_byte,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [31:0] out_hash_value,
  input  wire        out_path_error,
  output int         fail_count,
  output int         outstanding
);

  import apath_pkg::MAX_PATH_BYTES;

  localparam logic [31:0] TAIL_WORD_A   = 32'h9BE74448;
  localparam logic [31:0] TAIL_WORD_B   = 32'h66F42C48;
  localparam logic [31:0] ROT_SEED      = 32'hF4FA8928;
  localparam logic [31:0] LEFT_SEED     = 32'h7758B42B;
  localparam logic [31:0] RIGHT_SEED    = 32'h37A8470E;
  localparam logic [31:0] MIX_CONST     = 32'h267B0B11;
  localparam logic [31:0] R_FACTOR_SET  = 32'h02040801;
  localparam logic [31:0] R_FACTOR_KEEP = 32'hBFEF7FDF;
  localparam logic [31:0] L_FACTOR_SET  = 32'h00804021;
  localparam logic [31:0] L_FACTOR_KEEP = 32'h7DFEFBFF;

  typedef struct packed {
    logic [31:0] hash;
    logic        err;
  } path_result_t;

  path_result_t hash_queue[$];

  logic [31:0] word_acc;
  logic [31:0] rot_val;
  logic [31:0] left_lane;
  logic [31:0] right_lane;
  logic        bad_seen;
  int          byte_cnt;

  function automatic void clear_path();
    word_acc   = '0;
    byte_cnt   = 0;
    rot_val    = ROT_SEED;
    left_lane  = LEFT_SEED;
    right_lane = RIGHT_SEED;
    bad_seen   = 1'b0;
  endfunction

  // One mixing round on a 32-bit word.
  function automatic void hash_round(input logic [31:0] w);
    logic [31:0] mix, f1, f2, lo, hi, dh, new_right;
    logic [63:0] prod, sum;
    rot_val    = {rot_val[30:0], rot_val[31]};
    mix        = MIX_CONST ^ rot_val;
    right_lane = right_lane ^ w;
    left_lane  = left_lane ^ w;

    // right lane: end-around fold of the high half
    f1   = ((mix + left_lane) | R_FACTOR_SET) & R_FACTOR_KEEP;
    prod = 64'(f1) * 64'(right_lane);
    lo   = prod[31:0];
    hi   = prod[63:32];
    if (hi != 0) lo = lo + 32'd1;
    sum  = 64'(lo) + 64'(hi);
    lo   = sum[31:0];
    if (sum[32]) lo = lo + 32'd1;
    new_right = lo;

    // left lane factor sees the old right lane
    f2         = ((mix + right_lane) | L_FACTOR_SET) & L_FACTOR_KEEP;
    right_lane = new_right;

    prod = 64'(left_lane) * 64'(f2);
    lo   = prod[31:0];
    hi   = prod[63:32];
    sum  = 64'(hi) + 64'(hi);
    dh   = sum[31:0];
    if (sum[32]) lo = lo + 32'd1;
    sum  = 64'(lo) + 64'(dh);
    lo   = sum[31:0];
    if (sum[32]) lo = lo + 32'd2;
    left_lane = lo;
  endfunction

  function automatic void absorb_request(input logic [7:0] b, input logic present,
                                         input logic last);
    path_result_t res;
    logic         flagged;
    if (present) begin
      if (b[7]) bad_seen = 1'b1;
      if (byte_cnt < MAX_PATH_BYTES) begin
        word_acc = word_acc | (32'(b) << (8 * (byte_cnt % 4)));
        byte_cnt++;
        if (byte_cnt % 4 == 0) begin
          hash_round(word_acc);
          word_acc = '0;
        end
      end else begin
        byte_cnt = MAX_PATH_BYTES + 1;
      end
    end
    if (last) begin
      flagged = bad_seen || (byte_cnt > MAX_PATH_BYTES);
      if ((byte_cnt % 4 != 0) && !flagged) hash_round(word_acc);
      hash_round(TAIL_WORD_A);
      hash_round(TAIL_WORD_B);
      res.hash = flagged ? 32'd0 : (right_lane ^ left_lane);
      res.err  = flagged;
      hash_queue.push_back(res);
      clear_path();
    end
  endfunction

  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      clear_path();
      hash_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hash_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none pending: hash %h err %b",
                     $realtime, out_hash_value, out_path_error);
        end else begin
          want = hash_queue.pop_front();
          if (out_hash_value !== want.hash || out_path_error !== want.err) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: hash result: expected hash %h err %b, got hash %h err %b",
                       $realtime, want.hash, want.err, out_hash_value, out_path_error);
          end
        end
      end
      if (in_valid && in_ready)
        absorb_request(in_path_byte, in_byte_present, in_last_byte);
    end
    outstanding = hash_queue.size();
  end

endmodule

// File: verif/tb_top.sv
// Top of the path hash testbench: clock, reset, byte stimulus, result stalls.
// Instantiates archive_path_hash and path_hash_checker; gives the verdict.
`timescale 1ns / 100ps

module tb_top;

  // The limit is far above the slowest honest run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1200;
  localparam int DRAIN_WAIT  = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_path_byte;
  logic        in_byte_present;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_hash_value;
  logic        out_path_error;

  int fail_count;
  int outstanding;
  int cycle_count;
  int sent_items;    // requests that carry a byte or end a path
  int burst_left;
  bit calm;          // set for stretches where the sender never idles

  archive_path_hash DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_path_byte    (in_path_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value),
    .out_path_error  (out_path_error)
  );

  path_hash_checker hash_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_path_byte    (in_path_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value),
    .out_path_error  (out_path_error),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("archive_path_hash: mismatch");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until it is taken.
  // Bursts of back-to-back requests alternate with random gaps; during a gap
  // valid is low and the payload carries junk.
  task automatic put_request(input logic [7:0] b, input logic present,
                             input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid        = 1'b0;
        in_path_byte    = 8'($urandom);
        in_byte_present = 1'($urandom);
        in_last_byte    = 1'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid        = 1'b1;
    in_path_byte    = b;
    in_byte_present = present;
    in_last_byte    = last;
    do @(posedge clk); while (!in_ready);
    if (present || last) sent_items++;
  endtask

  // Sender holds off until every predicted hash has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // One path of len ASCII bytes; bad_at < 0 means no non-ASCII byte.
  // marker_end closes the path with a separate no-byte request.
  // Ignored requests (no byte, not last) are sprinkled in.
  task automatic send_path(input int len, input int bad_at, input bit marker_end);
    logic [7:0] b;
    if (len == 0) begin
      put_request(8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 127));
      if (i == bad_at) b = 8'($urandom_range(128, 255));
      if ($urandom_range(0, 15) == 0) put_request(8'($urandom), 1'b0, 1'b0);
      put_request(b, 1'b1, (i == len - 1) && !marker_end);
    end
    if (marker_end) put_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: out_ready follows a 16-bit pattern that is swapped out every
  // so often; all-ones patterns give stall-free stretches.
  initial begin
    logic [15:0] ready_pat;
    int          pat_idx;
    int          pat_life;
    out_ready = 1'b0;
    ready_pat = 16'hFFFF;
    pat_idx   = 0;
    pat_life  = 0;
    forever begin
      @(negedge clk);
      if (pat_life == 0) begin
        pat_life = $urandom_range(32, 256);
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = 16'h0101;
          default: ready_pat = 16'($urandom) | 16'h0001;
        endcase
      end
      pat_life--;
      out_ready = ready_pat[pat_idx];
      pat_idx   = (pat_idx + 1) % 16;
    end
  end

  initial begin
    int len;
    int bad_at;
    int r;
    bit paused;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_path_byte    = 8'h00;
    in_byte_present = 1'b0;
    in_last_byte    = 1'b0;
    sent_items      = 0;
    burst_left      = 0;
    calm            = 1'b0;
    paused          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty path, ignored step, byte extremes, exact word,
    // non-ASCII bytes, paths closed by a separate no-byte request.
    put_request(8'h00, 1'b0, 1'b1);
    put_request(8'hA5, 1'b0, 1'b0);
    put_request(8'h5A, 1'b0, 1'b1);
    put_request(8'h00, 1'b1, 1'b1);
    repeat (3) put_request(8'h7F, 1'b1, 1'b0);
    put_request(8'h7F, 1'b1, 1'b1);
    put_request(8'h80, 1'b1, 1'b1);
    put_request(8'hFF, 1'b1, 1'b0);
    put_request(8'h41, 1'b1, 1'b1);
    put_request(8'h61, 1'b1, 1'b0);
    put_request(8'h62, 1'b1, 1'b0);
    put_request(8'h63, 1'b1, 1'b0);
    put_request(8'h00, 1'b0, 1'b1);
    send_path(5, -1, 1'b0);
    send_path(2, 0, 1'b1);
    wait_drain();

    // Length limit: exactly at the limit, then one past it.
    send_path(apath_pkg::MAX_PATH_BYTES, -1, 1'b0);
    send_path(apath_pkg::MAX_PATH_BYTES + 1, -1, 1'($urandom));

    // Random paths: mostly short, some medium, a few around the limit.
    while (sent_items < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3)
        len = $urandom_range(apath_pkg::MAX_PATH_BYTES - 4,
                             apath_pkg::MAX_PATH_BYTES + 6);
      else if (r < 25)
        len = $urandom_range(13, 64);
      else
        len = $urandom_range(0, 12);
      bad_at = (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
      send_path(len, bad_at, ($urandom_range(0, 4) == 0));
      if (!paused && sent_items > ITEM_TARGET / 2) begin
        paused = 1'b1;
        wait_drain();
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("archive_path_hash: match");
    else
      $display("archive_path_hash: mismatch");
    $finish;
  end

endmodule
